/* rtl/i2crd_pkg.sv */
// ----------------------------------------------------------------------------
// i2crd_pkg: shared types for the I2C two-byte register reader
// Word layouts for the tick and result channels, configuration register
// indexes and reset values.
// ----------------------------------------------------------------------------
package i2crd_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REG_ADDR = 1'b1;

  localparam logic [6:0] DevAddrRst = 7'd54;
  localparam logic [7:0] RegAddrRst = 8'd12;

  // One tick word
  typedef struct packed {
    logic start_request;
    logic sda_in;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] read_value;
  } out_word_t;

  // Configuration values handed to the bus engine
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] register_address;
  } cfg_t;

endpackage

/* rtl/i2crd_engine.sv */
// ----------------------------------------------------------------------------
// i2crd_engine: bit-level I2C master sequencer
// Advances the bus one delay phase per accepted tick word and registers the
// resulting line levels and transaction status in the output stage.
// ----------------------------------------------------------------------------
module i2crd_engine
  import i2crd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_STOP_LO,
    PH_STOP_HI
  } phase_e;

  localparam logic [3:0] AckSlot = 4'd8;

  // Byte slots of one transaction
  localparam logic [2:0] ByteAddrWr = 3'd0;
  localparam logic [2:0] ByteReg    = 3'd1;
  localparam logic [2:0] ByteAddrRd = 3'd2;
  localparam logic [2:0] ByteRdHigh = 3'd3;
  localparam logic [2:0] ByteRdLow  = 3'd4;

  phase_e    phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] first_q, first_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;

  logic accept;
  logic drives;
  logic drv_bit;
  logic [2:0] byte_idx_inc;

  // Byte to shift out for a given slot
  function automatic logic [7:0] load_byte(input cfg_t cfg, input logic [2:0] idx);
    logic [7:0] res;
    res = 8'd0;
    if (idx == ByteAddrWr) res = {cfg.device_address, 1'b0};
    else if (idx == ByteReg) res = cfg.register_address;
    else if (idx == ByteAddrRd) res = {cfg.device_address, 1'b1};
    return res;
  endfunction

  // Take a new tick whenever the output stage is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Master drives data on write bits and on the read acknowledge slot
  assign drives       = (byte_idx_q < ByteRdHigh) ? (bit_cnt_q < AckSlot)
                                                  : (bit_cnt_q >= AckSlot);
  assign drv_bit      = (byte_idx_q < ByteRdHigh) ? shift_q[7]
                                                  : (byte_idx_q != ByteRdHigh);
  assign byte_idx_inc = byte_idx_q + 3'd1;

  // Next state and result for one bus phase
  always_comb begin
    phase_e p;
    logic   busy;
    logic   rel;
    p           = phase_q;
    busy        = 1'b1;
    rel         = 1'b0;
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    first_d     = first_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    byte_idx_d  = byte_idx_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (accept) begin
      out_d.done_res   = 1'b0;
      out_d.nack_error = 1'b0;
      out_d.read_value = 16'd0;

      // Launch a transaction from idle, or hold the lines
      if (p == PH_IDLE) begin
        if (in_word_i.start_request) begin
          byte_idx_d = ByteAddrWr;
          err_d      = 1'b0;
          p          = PH_START_HI;
        end else begin
          busy = 1'b0;
        end
      end

      if (busy) begin
        case (p)
          PH_START_HI: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_START_LO;
          end
          PH_START_LO: begin
            scl_d     = 1'b1;
            sda_d     = 1'b0;
            shift_d   = load_byte(cfg_i, byte_idx_q);
            bit_cnt_d = 4'd0;
            phase_d   = PH_BIT_LO;
          end
          PH_BIT_LO: begin
            scl_d = 1'b0;
            if (drives) sda_d = drv_bit;
            else rel = 1'b1;
            phase_d = PH_BIT_HI;
          end
          PH_BIT_HI: begin
            scl_d = 1'b1;
            if (drives) sda_d = drv_bit;
            else rel = 1'b1;
            phase_d = PH_BIT_LO;
            if (bit_cnt_q < AckSlot) begin
              // Shift out write data or shift in read data
              if (byte_idx_q < ByteRdHigh) shift_d = {shift_q[6:0], 1'b0};
              else shift_d = {shift_q[6:0], in_word_i.sda_in};
              bit_cnt_d = bit_cnt_q + 4'd1;
            end else if (byte_idx_q < ByteRdHigh) begin
              // Acknowledge of a write byte: only the first one counts
              if (byte_idx_q == ByteAddrWr && in_word_i.sda_in) begin
                err_d   = 1'b1;
                phase_d = PH_STOP_LO;
              end else begin
                byte_idx_d = byte_idx_inc;
                if (byte_idx_inc == ByteAddrRd) begin
                  phase_d = PH_START_HI;
                end else begin
                  shift_d   = load_byte(cfg_i, byte_idx_inc);
                  bit_cnt_d = 4'd0;
                end
              end
            end else if (byte_idx_q == ByteRdHigh) begin
              first_d    = shift_q;
              byte_idx_d = ByteRdLow;
              shift_d    = 8'd0;
              bit_cnt_d  = 4'd0;
            end else begin
              phase_d = PH_STOP_LO;
            end
          end
          PH_STOP_LO: begin
            scl_d   = 1'b1;
            sda_d   = 1'b0;
            phase_d = PH_STOP_HI;
          end
          PH_STOP_HI: begin
            scl_d            = 1'b1;
            sda_d            = 1'b1;
            out_d.done_res   = 1'b1;
            out_d.nack_error = err_q;
            out_d.read_value = err_q ? 16'd0 : {first_q, shift_q};
            phase_d          = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      out_d.scl_out     = scl_d;
      out_d.sda_out     = sda_d;
      out_d.sda_release = rel;
      out_d.busy_res    = busy;
      out_valid_d       = 1'b1;
    end
  end

  // Hold bus state and the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      first_q     <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      byte_idx_q  <= ByteAddrWr;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      first_q     <= first_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      byte_idx_q  <= byte_idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/i2c_two_byte_register_reader_core.sv */
// ----------------------------------------------------------------------------
// i2c_two_byte_register_reader_core: I2C master two-byte register read
// Bit-level I2C master that runs write-address, register, repeated start,
// read-address and two read bytes, one bus delay phase per tick word.
//
//   channel  | signals                          | word
//   ---------+----------------------------------+------------------------------
//   tick in  | in_valid_i / in_ready_o          | in_word_t (request, sda level)
//   result   | out_valid_o / out_ready_i        | out_word_t (lines, status)
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i | address registers, no wait
//
// One tick word per clock while no result is stalled; each result appears in the cycle after its tick.
// The bus sequencer updates its phase state in the cycle a tick is taken.
// Reset puts the bus idle with both lines high and loads address 54, reg 12.
// A stalled result holds in the output stage; a new tick is taken in the
// same cycle the held result is taken.
// ----------------------------------------------------------------------------
module i2c_two_byte_register_reader_core
  import i2crd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  cfg_t cfg_q, cfg_d;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEV_ADDR: cfg_d.device_address   = cfg_wdata_i[6:0];
        CFG_REG_ADDR: cfg_d.register_address = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address   <= DevAddrRst;
      cfg_q.register_address <= RegAddrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2crd_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule
